// ----- design/sobel_pkg.sv -----
`timescale 1ns / 1ps

package sobel_pkg;

  // Field widths of the pixel and result words.
  localparam int unsigned PIXEL_W = 8;
  localparam int unsigned VALUE_W = 11;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

  // Register reset values.
  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = 11'd640;
  localparam logic             RST_MAGNITUDE_MODE = 1'b1;
  localparam logic [CFG_W-1:0] RST_EDGE_THRESHOLD = 11'd128;

  // Threshold mode output levels.
  localparam logic [VALUE_W-1:0] EDGE_ON  = 11'd255;
  localparam logic [VALUE_W-1:0] EDGE_OFF = 11'd0;

  // Smallest row length that the block works with.
  localparam logic [CFG_W-1:0] MIN_WIDTH = 11'd3;

  // Sum of squares and square root sizes.
  localparam int unsigned SQ_W   = 21;
  localparam int unsigned ROOT_STEPS = 11;

endpackage

// ----- design/sobel_edge_magnitude_top.sv -----
`timescale 1ns / 1ps

// Sobel edge magnitude over a raster stream of 8-bit grey pixels.
// Input channel s_axis: tdata carries the pixel, tuser the frame start flag
// that restarts row and column counting at that pixel. Output channel m_axis:
// tdata carries the edge value, tlast marks the last word of an output row.
// Rows 0 and 1 and columns 0 and 1 of a frame give no output word.
// The block handles one pixel at a time. An accepted pixel reads both line
// stores (one synchronous memory read), then forms the gradients, then their
// squares. In gradient mode an 11-step iterative square root follows; in
// threshold mode the sum is compared with the squared threshold. The next
// pixel is accepted only after the current one is done; a pixel without output
// is done after the read. A result is then loaded into the output register.
// A finished word waits in the output register while the next pixel is
// accepted; only the loading of a new result waits for m_axis_tready.
// Reset sets the registers to width 640, gradient mode and threshold 128,
// and clears the counters; the line stores are not cleared and need no
// clearing pass, as every entry is written before it is used.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at the
// clock edge and must only be made while the block is idle.
module sobel_edge_magnitude_top #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [sobel_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sobel_pkg::CFG_W-1:0]   cfg_data_i,
  // Pixel input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] pixel
  input  logic                          s_axis_tuser,  // [0] frame_start
  // Edge output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // [10:0] edge_value
  output logic                          m_axis_tlast   // row_last
);

  import sobel_pkg::*;

  localparam int unsigned CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WCMP = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam logic [WCMP-1:0] MAX_W_C = WCMP'(MAX_WIDTH);
  localparam logic [WCMP-1:0] MIN_W_C = WCMP'(MIN_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SQ,
    S_ROOT,
    S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [CFG_W-1:0] width_cfg_q;
  logic             mode_q;
  logic [CFG_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg_q <= RST_IMAGE_WIDTH;
      mode_q      <= RST_MAGNITUDE_MODE;
      thr_q       <= RST_EDGE_THRESHOLD;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:    width_cfg_q <= cfg_data_i;
        REG_MAGNITUDE_MODE: mode_q      <= cfg_data_i[0];
        REG_EDGE_THRESHOLD: thr_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Counters, window and working registers.
  logic [CW-1:0]      col_q;
  logic [1:0]         row_q;          // saturates at 2, only rows 0, 1 and later matter
  logic [PIXEL_W-1:0] px_q;
  logic [PIXEL_W-1:0] win_q [6];
  logic [PIXEL_W-1:0] top_rd_q;
  logic [PIXEL_W-1:0] mid_rd_q;
  logic [9:0]         ax_q;
  logic [9:0]         ay_q;
  logic [21:0]        thr_sq_q;
  logic               last_q;
  logic [SQ_W-1:0]    rem_q;
  logic [SQ_W-1:0]    root_q;
  logic [SQ_W-1:0]    bit_q;
  logic [VALUE_W-1:0] res_q;
  logic               m_valid_q;
  logic [VALUE_W-1:0] m_data_q;
  logic               m_last_q;

  // Line stores: read on acceptance, written back in the read-data cycle.
  logic [PIXEL_W-1:0] line_a [MAX_WIDTH];
  logic [PIXEL_W-1:0] line_b [MAX_WIDTH];
  logic               accept;
  logic [CW-1:0]      rd_addr;
  logic               wr_en;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign rd_addr = s_axis_tuser ? '0 : col_q;
  assign wr_en   = (state_q == S_READ);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_rd_q <= line_b[rd_addr];
      mid_rd_q <= line_a[rd_addr];
    end
    if (wr_en) begin
      line_b[col_q] <= mid_rd_q;
      line_a[col_q] <= px_q;
    end
  end

  // Width in use and end of row.
  logic [WCMP-1:0] width_ext;
  logic [WCMP-1:0] width_use;
  logic [WCMP-1:0] col_inc;
  logic            row_end;

  always_comb begin
    width_ext = WCMP'(width_cfg_q);
    if (width_ext < MIN_W_C) begin
      width_use = MIN_W_C;
    end else if (width_ext > MAX_W_C) begin
      width_use = MAX_W_C;
    end else begin
      width_use = width_ext;
    end
    col_inc = WCMP'(col_q) + WCMP'(1);
    row_end = (col_inc >= width_use);
  end

  // Gradient sums for the window completed by the current pixel.
  logic [9:0] gx_pos, gx_neg, gy_pos, gy_neg;
  logic [9:0] ax_d, ay_d;
  logic       full_win;

  always_comb begin
    gx_pos = 10'(top_rd_q) + {1'b0, mid_rd_q, 1'b0} + 10'(px_q);
    gx_neg = 10'(win_q[0]) + {1'b0, win_q[2], 1'b0} + 10'(win_q[4]);
    gy_pos = 10'(win_q[4]) + {1'b0, win_q[5], 1'b0} + 10'(px_q);
    gy_neg = 10'(win_q[0]) + {1'b0, win_q[1], 1'b0} + 10'(top_rd_q);
    ax_d = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
    ay_d = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
    full_win = (row_q == 2'd2) && (col_q >= CW'(2));
  end

  // Sum of squares and one square root step.
  logic [SQ_W-1:0] sum_sq;
  logic [SQ_W:0]   trial;
  logic [SQ_W-1:0] rem_d;
  logic [SQ_W-1:0] root_d;

  always_comb begin
    sum_sq = SQ_W'(ax_q * ax_q) + SQ_W'(ay_q * ay_q);
    trial  = {1'b0, root_q} + {1'b0, bit_q};
    if ({1'b0, rem_q} >= trial) begin
      rem_d  = rem_q - trial[SQ_W-1:0];
      root_d = (root_q >> 1) + bit_q;
    end else begin
      rem_d  = rem_q;
      root_d = root_q >> 1;
    end
  end

  // Control sequence and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      col_q     <= '0;
      row_q     <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      // The output state reloads the register itself whenever the word drains.
      if (m_axis_tready && state_q != S_OUT) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            px_q <= s_axis_tdata[PIXEL_W-1:0];
            if (s_axis_tuser) begin
              col_q <= '0;
              row_q <= '0;
            end
            state_q <= S_READ;
          end
        end
        S_READ: begin
          ax_q     <= ax_d;
          ay_q     <= ay_d;
          thr_sq_q <= 22'(thr_q * thr_q);
          last_q   <= row_end;
          win_q[0] <= win_q[1];
          win_q[1] <= top_rd_q;
          win_q[2] <= win_q[3];
          win_q[3] <= mid_rd_q;
          win_q[4] <= win_q[5];
          win_q[5] <= px_q;
          if (row_end) begin
            col_q <= '0;
            if (row_q != 2'd2) begin
              row_q <= row_q + 2'd1;
            end
          end else begin
            col_q <= col_q + CW'(1);
          end
          state_q <= full_win ? S_SQ : S_IDLE;
        end
        S_SQ: begin
          rem_q  <= sum_sq;
          root_q <= '0;
          bit_q  <= SQ_W'(1) << (2 * (ROOT_STEPS - 1));
          res_q  <= ({1'b0, sum_sq} > thr_sq_q) ? EDGE_ON : EDGE_OFF;
          state_q <= mode_q ? S_ROOT : S_OUT;
        end
        S_ROOT: begin
          rem_q  <= rem_d;
          root_q <= root_d;
          bit_q  <= bit_q >> 2;
          if (bit_q[0]) begin
            res_q   <= root_d[VALUE_W-1:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= res_q;
            m_last_q  <= last_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, m_data_q};
  assign m_axis_tlast  = m_last_q;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import sobel_pkg::*;

  localparam int unsigned LINE_DEPTH    = 1024;
  localparam int unsigned RANDOM_ITEMS  = 350;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SHOWN_ERRORS  = 10;
  localparam int unsigned TDATA_W       = 16;

  // Index past the end of the register list; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int unsigned {FILL_NOISE, FILL_RAMP, FILL_BLOCKS, FILL_FLAT} fill_kind_e;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               frame_start;
  } pixel_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] edge_value;
    logic               row_last;
  } edge_word_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 m_axis_tlast;

  // Shadow of the block's registers and pixel history.
  logic [CFG_W-1:0]   width_reg     = RST_IMAGE_WIDTH;
  logic               mode_reg      = RST_MAGNITUDE_MODE;
  logic [CFG_W-1:0]   threshold_reg = RST_EDGE_THRESHOLD;
  logic [PIXEL_W-1:0] line_above     [LINE_DEPTH];
  logic [PIXEL_W-1:0] line_two_above [LINE_DEPTH];
  logic [PIXEL_W-1:0] window_px      [6];
  int unsigned        column_pos = 0;
  int unsigned        row_pos    = 0;

  pixel_word_t pixels_pending[$];
  edge_word_t  edges_due[$];

  int unsigned words_offered = 0;
  int unsigned words_taken   = 0;
  int unsigned send_gap      = 0;
  int unsigned recv_gap      = 0;
  int unsigned stall_cycles  = 0;
  int unsigned mismatches    = 0;
  bit          send_idling   = 1'b0;
  bit          recv_idling   = 1'b0;

  sobel_edge_magnitude_top #(
    .MAX_WIDTH(LINE_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // Row length actually used for a given register value.
  function automatic int unsigned width_in_effect(input logic [CFG_W-1:0] row_len);
    if (row_len < MIN_WIDTH) begin
      return MIN_WIDTH;
    end
    if (row_len > LINE_DEPTH) begin
      return LINE_DEPTH;
    end
    return row_len;
  endfunction

  // Advances the shadow state by one pixel and queues the edge word it yields.
  task automatic predict_edge(input pixel_word_t w);
    int unsigned span, c, s, root;
    int p00, p01, p02, p10, p12, p20, p21, p22, gx, gy;
    logic [PIXEL_W-1:0] top, mid;
    edge_word_t res;
    span = width_in_effect(width_reg);
    if (w.frame_start) begin
      column_pos = 0;
      row_pos = 0;
    end
    c = (column_pos < LINE_DEPTH) ? column_pos : LINE_DEPTH - 1;
    top = line_two_above[c];
    mid = line_above[c];

    // A full 3x3 window exists from the third row and third column onwards.
    if (row_pos >= 2 && column_pos >= 2) begin
      p00 = window_px[0];
      p01 = window_px[1];
      p02 = top;
      p10 = window_px[2];
      p12 = mid;
      p20 = window_px[4];
      p21 = window_px[5];
      p22 = w.pixel;
      gx = (p02 + 2 * p12 + p22) - (p00 + 2 * p10 + p20);
      gy = (p20 + 2 * p21 + p22) - (p00 + 2 * p01 + p02);
      s = gx * gx + gy * gy;
      if (mode_reg) begin
        // Build the integer root one bit at a time from the top.
        root = 0;
        for (int b = VALUE_W - 1; b >= 0; b--) begin
          if ((root | (1 << b)) * (root | (1 << b)) <= s) begin
            root = root | (1 << b);
          end
        end
        res.edge_value = root[VALUE_W-1:0];
      end else begin
        res.edge_value = (s > int'(threshold_reg) * int'(threshold_reg)) ? EDGE_ON : EDGE_OFF;
      end
      res.row_last = (column_pos + 1 >= span);
      edges_due.push_back(res);
    end

    line_two_above[c] = mid;
    line_above[c] = w.pixel;
    window_px[0] = window_px[1];
    window_px[1] = top;
    window_px[2] = window_px[3];
    window_px[3] = mid;
    window_px[4] = window_px[5];
    window_px[5] = w.pixel;

    if (column_pos + 1 >= span) begin
      column_pos = 0;
      if (row_pos < 65535) begin
        row_pos++;
      end
    end else begin
      column_pos++;
    end
  endtask

  // Waits until no pixel is pending and no edge word is outstanding, then lets
  // the block finish any pixel that yields no word.
  task automatic settle();
    do begin
      @(negedge clk_i);
    end while (pixels_pending.size() != 0 || words_taken != words_offered ||
               edges_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = val;
      end
      REG_MAGNITUDE_MODE: begin
        mode_reg = val[0];
      end
      REG_EDGE_THRESHOLD: begin
        threshold_reg = val;
      end
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Drains the block, reprograms it and sets the idling behaviour of both sides.
  task automatic begin_phase(input logic [CFG_W-1:0] row_len, input logic mode,
                             input logic [CFG_W-1:0] threshold, input bit send, input bit recv);
    settle();
    write_reg(REG_UNUSED, CFG_W'($urandom));
    write_reg(REG_IMAGE_WIDTH, row_len);
    write_reg(REG_MAGNITUDE_MODE, CFG_W'(mode));
    write_reg(REG_EDGE_THRESHOLD, threshold);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_idling = send;
    recv_idling = recv;
  endtask

  // Queues one frame in raster order; only its first pixel may carry the start flag.
  task automatic queue_frame(input int unsigned span, input int unsigned length,
                             input fill_kind_e kind, input bit fresh);
    int unsigned base, step, row_step, block, r, c;
    logic [PIXEL_W-1:0] px;
    base = $urandom_range(0, 255);
    step = $urandom_range(0, 40);
    row_step = $urandom_range(0, 40);
    block = $urandom_range(1, 3);
    for (int unsigned i = 0; i < length; i++) begin
      r = i / span;
      c = i % span;
      case (kind)
        FILL_NOISE: begin
          px = PIXEL_W'($urandom_range(0, 255));
        end
        FILL_RAMP: begin
          px = PIXEL_W'(base + c * step + r * row_step);
        end
        FILL_BLOCKS: begin
          px = (((c / block) + (r / block) + base) % 2 != 0) ? 8'hFF : 8'h00;
        end
        default: begin
          px = PIXEL_W'(base + $urandom_range(0, 12));
        end
      endcase
      pixels_pending.push_back(pixel_word_t'{px, fresh && i == 0});
    end
  endtask

  // Pixel driver: holds a word until it is taken, with random gaps.
  always @(negedge clk_i) begin : drive_pixels
    pixel_word_t next_word;
    if (rst_ni && (!s_axis_tvalid || words_taken == words_offered)) begin
      if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pixels_pending.size() > 0 && send_idling && $urandom_range(0, 5) == 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= $urandom_range(0, 8);
      end else if (pixels_pending.size() > 0) begin
        next_word = pixels_pending.pop_front();
        s_axis_tdata  <= next_word.pixel;
        s_axis_tuser  <= next_word.frame_start;
        s_axis_tvalid <= 1'b1;
        words_offered = words_offered + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output back-pressure in random bursts.
  always @(negedge clk_i) begin : drive_ready
    if (recv_gap > 0) begin
      m_axis_tready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else if (recv_idling && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      recv_gap <= $urandom_range(0, 8);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Checks output words against the predicted ones, then predicts from the
  // accepted pixel; also ends the run if the streams stop moving.
  always @(posedge clk_i) begin : check_words
    edge_word_t due;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (edges_due.size() == 0) begin
          if (mismatches < SHOWN_ERRORS) begin
            $display("Unexpected edge word: tdata %0d tlast %0b", m_axis_tdata, m_axis_tlast);
          end
          mismatches++;
        end else begin
          due = edges_due.pop_front();
          if (m_axis_tdata !== {{(TDATA_W - VALUE_W){1'b0}}, due.edge_value} ||
              m_axis_tlast !== due.row_last) begin
            if (mismatches < SHOWN_ERRORS) begin
              $display("Edge word mismatch: expected value %0d last %0b, got tdata %0d last %0b",
                       due.edge_value, due.row_last, m_axis_tdata, m_axis_tlast);
            end
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        words_taken <= words_taken + 1;
        predict_edge(pixel_word_t'{s_axis_tdata, s_axis_tuser});
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : run_test
    int unsigned random_items, span, length, frames;
    logic [CFG_W-1:0] row_len, threshold;
    logic [PIXEL_W-1:0] px;
    random_items = 0;
    foreach (window_px[i]) begin
      window_px[i] = '0;
    end
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Register values from reset: a short stretch at the reset width yields no
    // word, then narrow frames with mode and threshold at reset values, then in threshold mode.
    @(posedge clk_i);
    send_idling = 1'b1;
    recv_idling = 1'b1;
    queue_frame(width_in_effect(width_reg), 40, FILL_NOISE, 1'b1);
    settle();
    write_reg(REG_IMAGE_WIDTH, 11'd6);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    queue_frame(6, 30, FILL_RAMP, 1'b1);
    settle();
    write_reg(REG_MAGNITUDE_MODE, 11'd0);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    queue_frame(6, 36, FILL_NOISE, 1'b1);

    // Width below the minimum runs as three; hand-made 3x3 frames give the
    // steepest left-to-right gradient, a flat white field and a diagonal corner.
    begin_phase('0, 1'b1, RST_EDGE_THRESHOLD, 1'b1, 1'b1);
    for (int f = 0; f < 3; f++) begin
      for (int i = 0; i < 9; i++) begin
        case (f)
          0: px = (i % 3 == 2 || i == 7) ? 8'hFF : 8'h00;
          1: px = 8'hFF;
          default: px = (i == 0 || i == 1 || i == 3) ? 8'hFF : 8'h00;
        endcase
        pixels_pending.push_back(pixel_word_t'{px, i == 0});
      end
    end

    // Threshold extremes: zero marks every window with a nonzero gradient, the largest none.
    begin_phase(11'd2, 1'b0, '0, 1'b1, 1'b0);
    queue_frame(3, 15, FILL_NOISE, 1'b1);
    queue_frame(3, 15, FILL_BLOCKS, 1'b1);
    queue_frame(3, 12, FILL_FLAT, 1'b1);
    begin_phase(11'd5, 1'b0, '1, 1'b0, 1'b1);
    queue_frame(5, 25, FILL_BLOCKS, 1'b1);
    queue_frame(5, 20, FILL_NOISE, 1'b1);

    // Width above the line store size is clamped to its depth; a short stretch
    // at that width yields no word.
    begin_phase('1, 1'b0, CFG_W'($urandom_range(0, 600)), 1'b1, 1'b1);
    queue_frame(LINE_DEPTH, 30, FILL_RAMP, 1'b1);

    // Random frames, some cut short and some running on without a start flag.
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: row_len = CFG_W'($urandom_range(0, 2));
        1: row_len = CFG_W'($urandom_range(17, 48));
        default: row_len = CFG_W'($urandom_range(3, 16));
      endcase
      case ($urandom_range(0, 4))
        0: threshold = '0;
        1: threshold = '1;
        2: threshold = CFG_W'($urandom_range(0, 40));
        3: threshold = CFG_W'($urandom_range(0, 400));
        default: threshold = CFG_W'($urandom_range(0, 1500));
      endcase
      begin_phase(row_len, 1'($urandom_range(0, 1)), threshold,
                  $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
      span = width_in_effect(width_reg);
      frames = $urandom_range(2, 4);
      for (int k = 0; k < frames; k++) begin
        length = span * $urandom_range(3, 6);
        if ($urandom_range(0, 4) == 0) begin
          length = $urandom_range(1, length - 1);
        end
        queue_frame(span, length, fill_kind_e'($urandom_range(0, 3)),
                    k == 0 || $urandom_range(0, 7) != 0);
        random_items += length;
      end
    end

    // Closing stretch at full rate on both sides.
    begin_phase(CFG_W'($urandom_range(3, 16)), 1'($urandom_range(0, 1)),
                CFG_W'($urandom_range(0, 300)), 1'b0, 1'b0);
    span = width_in_effect(width_reg);
    queue_frame(span, span * 4, FILL_NOISE, 1'b1);
    queue_frame(span, span * 4, FILL_RAMP, 1'b1);

    settle();
    if (mismatches == 0 && edges_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sobel_edge_magnitude_top.f -----
design/sobel_pkg.sv
design/sobel_edge_magnitude_top.sv
sim/tb_top.sv
